// ----- design/lfsd_pkg.sv -----
// ----------------------------------------------------------------------------
// LED fade schedule dimmer package
// Shared codes, widths and types of the fade and schedule dimmer.
// ----------------------------------------------------------------------------
`default_nettype none

package lfsd_pkg;

    localparam int NUM_PTS   = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 49;
    localparam int MUL_A_W   = 18;
    localparam int MUL_B_W   = 17;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int DIVD_W    = 34;
    localparam int DIVS_W    = 18;

    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_PIXEL  = 2'd1;
    localparam logic [1:0] OP_SWITCH = 2'd2;

    localparam logic [1:0] MODE_OFF      = 2'd0;
    localparam logic [1:0] MODE_FADE_IN  = 2'd1;
    localparam logic [1:0] MODE_ON       = 2'd2;
    localparam logic [1:0] MODE_FADE_OUT = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PT_A   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PT_D   = 3'd5;

    localparam logic [16:0]        BRI_FULL    = 17'd65536;
    localparam logic signed [18:0] DAY_SECONDS = 19'sd86400;
    localparam logic [DIVS_W-1:0]  PIX_DIV     = 18'd261120;
    localparam logic [DIVS_W-1:0]  PIX_HALF    = 18'd130560;

    typedef logic [NUM_PTS-1:0][16:0] t_pt_vec;

    typedef struct packed {
        logic        direct;
        logic [16:0] bri;
        logic [16:0] bp;
        logic [16:0] bn;
        logic [16:0] span;
        logic [16:0] dt;
    } t_seg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCHED,
        S_MUL1,
        S_MUL2,
        S_DIV_BRI,
        S_MUL_EFF,
        S_DIV_EFF,
        S_MUL_PIX,
        S_DIV_PIX,
        S_FIN
    } t_state;

endpackage

`default_nettype wire

// ----- design/lfsd_if.sv -----
// ----------------------------------------------------------------------------
// LED fade schedule dimmer channels
// Valid and ready channels for items, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface lfsd_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [15:0] elapsed_ms;
    logic [16:0] second_of_day;
    logic [7:0]  channel_value;
    logic        switch_on;

    modport source (output valid, opcode, elapsed_ms, second_of_day, channel_value,
                    switch_on, input ready);
    modport sink (input valid, opcode, elapsed_ms, second_of_day, channel_value,
                  switch_on, output ready);
endinterface

interface lfsd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] value;
    logic [1:0] fade_mode;

    modport source (output valid, value, fade_mode, input ready);
    modport sink (input valid, value, fade_mode, output ready);
endinterface

interface lfsd_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [48:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- design/lfsd_mul.sv -----
// ----------------------------------------------------------------------------
// LED fade schedule dimmer multiplier
// Shift and add multiplier that retires one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lfsd_mul
    import lfsd_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [MUL_A_W-1:0] i_a,
    input  wire logic [MUL_B_W-1:0] i_b,
    output logic      [MUL_P_W-1:0] o_prod,
    output logic                    o_done,
    output logic                    o_busy
);

    localparam int CNT_W = $clog2(MUL_B_W + 1);

    logic [CNT_W-1:0]   r_cnt;
    logic               r_done;
    logic [MUL_A_W-1:0] r_a;
    logic [MUL_P_W-1:0] r_p;
    logic [MUL_A_W:0]   sum;

    assign sum = {1'b0, r_p[MUL_P_W-1:MUL_B_W]} + (r_p[0] ? {1'b0, r_a} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= CNT_W'(MUL_B_W);
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CNT_W'(1));
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_p <= {{MUL_A_W{1'b0}}, i_b};
        end else if (r_cnt != '0) begin
            r_p <= {sum, r_p[MUL_B_W-1:1]};
        end
    end

    assign o_prod = r_p;
    assign o_done = r_done;
    assign o_busy = (r_cnt != '0);

endmodule

`default_nettype wire

// ----- design/lfsd_div.sv -----
// ----------------------------------------------------------------------------
// LED fade schedule dimmer divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lfsd_div
    import lfsd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [DIVD_W-1:0] i_dividend,
    input  wire logic [DIVS_W-1:0] i_divisor,
    output logic      [DIVD_W-1:0] o_quot,
    output logic                   o_done,
    output logic                   o_busy
);

    localparam int CNT_W = $clog2(DIVD_W + 1);

    logic [CNT_W-1:0]  r_cnt;
    logic              r_done;
    logic [DIVS_W-1:0] r_div;
    logic [DIVS_W-1:0] r_rem;
    logic [DIVD_W-1:0] r_q;
    logic [DIVS_W:0]   trial;
    logic              fits;

    assign trial = {r_rem, r_q[DIVD_W-1]};
    assign fits  = (trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= CNT_W'(DIVD_W);
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CNT_W'(1));
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_divisor;
            r_rem <= '0;
            r_q   <= i_dividend;
        end else if (r_cnt != '0) begin
            r_rem <= fits ? DIVS_W'(trial - {1'b0, r_div}) : trial[DIVS_W-1:0];
            r_q   <= {r_q[DIVD_W-2:0], fits};
        end
    end

    assign o_quot = r_q;
    assign o_done = r_done;
    assign o_busy = (r_cnt != '0);

endmodule

`default_nettype wire

// ----- design/lfsd_sched.sv -----
// ----------------------------------------------------------------------------
// LED fade schedule dimmer segment finder
// Picks the schedule segment around a time of day and its span and offset.
// ----------------------------------------------------------------------------
`default_nettype none

module lfsd_sched
    import lfsd_pkg::*;
#(
    parameter int MAX_POINTS = 4
) (
    input  wire logic        i_enable,
    input  wire logic [2:0]  i_count,
    input  wire logic [16:0] i_t,
    input  wire t_pt_vec     i_pt_time,
    input  wire t_pt_vec     i_pt_bri,
    output t_seg             o_seg
);

    logic [2:0]        n;
    logic [1:0]        nx;
    logic [1:0]        pv;
    logic              found;
    logic signed [18:0] sp;
    logic signed [18:0] dts;

    always_comb begin
        n = (i_count > 3'(MAX_POINTS)) ? 3'(MAX_POINTS) : i_count;
        found = 1'b0;
        nx = 2'd0;
        for (int i = 0; i < NUM_PTS; i++) begin
            if (!found && (3'(i) < n) && (i_pt_time[i] >= i_t)) begin
                found = 1'b1;
                nx = 2'(i);
            end
        end
        pv = (nx == 2'd0) ? 2'(n - 3'd1) : nx - 2'd1;

        sp = $signed({2'b00, i_pt_time[nx]}) - $signed({2'b00, i_pt_time[pv]});
        if (sp < 0) begin
            sp = sp + DAY_SECONDS;
        end
        dts = $signed({2'b00, i_t}) - $signed({2'b00, i_pt_time[pv]});
        if (dts < 0) begin
            dts = dts + DAY_SECONDS;
        end
        if (dts < 0) begin
            dts = '0;
        end
        if (dts > sp) begin
            dts = sp;
        end

        o_seg.direct = 1'b1;
        o_seg.bri    = BRI_FULL;
        o_seg.bp     = i_pt_bri[pv];
        o_seg.bn     = i_pt_bri[nx];
        o_seg.span   = sp[16:0];
        o_seg.dt     = dts[16:0];
        if (!i_enable || n == 3'd0) begin
            o_seg.bri = BRI_FULL;
        end else if (n == 3'd1) begin
            o_seg.bri = i_pt_bri[0];
        end else if (sp <= 0) begin
            o_seg.bri = i_pt_bri[nx];
        end else begin
            o_seg.direct = 1'b0;
            o_seg.bri    = i_pt_bri[nx];
        end
    end

endmodule

`default_nettype wire

// ----- design/led_fade_schedule_dimmer.sv -----
// A switch goes straight to its result beat; a pixel takes one serial multiply and
// one serial divide; a tick takes a multiply and a divide, and a tick that
// interpolates the schedule takes two multiplies and a divide before them.
// One item is in work at a time, so a new beat is accepted in the cycle after
// the result is loaded.
// Reset clears the fade state, the effective level and every configuration register.
// ----------------------------------------------------------------------------
// LED fade schedule dimmer
// Fade ramp, time of day schedule and channel scaling on serial arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

module led_fade_schedule_dimmer
    import lfsd_pkg::*;
#(
    parameter int FADE_MS    = 1000,
    parameter int MAX_POINTS = 4
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    lfsd_cfg_if.sink   i_cfg,
    lfsd_in_if.sink    i_in,
    lfsd_out_if.source o_out
);

    localparam logic [17:0]       FULL     = 18'(255 * FADE_MS);
    localparam logic [DIVS_W-1:0] EFF_DIV  = DIVS_W'(FADE_MS * 64);
    localparam logic [DIVS_W-1:0] EFF_HALF = DIVS_W'(FADE_MS * 32);

    t_state r_state;
    t_state n_state;

    logic        r_enable;
    logic [2:0]  r_count;
    t_pt_vec     r_pt_time;
    t_pt_vec     r_pt_bri;

    logic [1:0]  r_mode, n_mode;
    logic [17:0] r_fade, n_fade;
    logic [17:0] r_eff, n_eff;
    logic        r_ovld, n_ovld;
    logic [7:0]  r_oval, n_oval;
    logic [1:0]  r_omode, n_omode;

    logic [16:0] r_t, n_t;
    logic [16:0] r_bn, n_bn;
    logic [16:0] r_dt, n_dt;
    logic [16:0] r_span, n_span;
    logic [MUL_P_W-1:0] r_sum, n_sum;
    logic [7:0]  r_res, n_res;

    logic               mul_start, mul_done, mul_busy;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] mul_prod;
    logic               div_start, div_done, div_busy;
    logic [DIVD_W-1:0]  div_dvd;
    logic [DIVS_W-1:0]  div_dvs;
    logic [DIVD_W-1:0]  div_quot;

    t_seg        seg;
    logic        in_acc;
    logic        out_free;
    logic [23:0] step;
    logic [18:0] eff_rnd;
    logic [18:0] quot_rnd;
    logic [16:0] b_sat;

    assign in_acc   = i_in.valid && i_in.ready;
    assign out_free = !r_ovld || o_out.ready;
    assign step     = {i_in.elapsed_ms, 8'd0} - {8'd0, i_in.elapsed_ms};
    assign eff_rnd  = {1'b0, r_eff} + 19'd512;
    assign quot_rnd = {1'b0, div_quot[17:0]} + 19'd512;
    assign b_sat    = (i_cfg.data[48:32] > BRI_FULL) ? BRI_FULL : i_cfg.data[48:32];

    assign i_cfg.ready     = 1'b1;
    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_ovld;
    assign o_out.value     = r_oval;
    assign o_out.fade_mode = r_omode;

    lfsd_sched #(
        .MAX_POINTS(MAX_POINTS)
    ) u_sched (
        .i_enable (r_enable),
        .i_count  (r_count),
        .i_t      (r_t),
        .i_pt_time(r_pt_time),
        .i_pt_bri (r_pt_bri),
        .o_seg    (seg)
    );

    lfsd_mul u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(mul_start),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_prod),
        .o_done (mul_done),
        .o_busy (mul_busy)
    );

    lfsd_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_dividend(div_dvd),
        .i_divisor (div_dvs),
        .o_quot    (div_quot),
        .o_done    (div_done),
        .o_busy    (div_busy)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_in.opcode)
                        OP_TICK:  n_state = S_SCHED;
                        OP_PIXEL: n_state = S_MUL_PIX;
                        default:  n_state = S_FIN;
                    endcase
                end
            end
            S_SCHED:   n_state = seg.direct ? S_MUL_EFF : S_MUL1;
            S_MUL1:    if (mul_done) n_state = S_MUL2;
            S_MUL2:    if (mul_done) n_state = S_DIV_BRI;
            S_DIV_BRI: if (div_done) n_state = S_MUL_EFF;
            S_MUL_EFF: if (mul_done) n_state = S_DIV_EFF;
            S_DIV_EFF: if (div_done) n_state = S_FIN;
            S_MUL_PIX: if (mul_done) n_state = S_DIV_PIX;
            S_DIV_PIX: if (div_done) n_state = S_FIN;
            S_FIN:     if (out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_mode    = r_mode;
        n_fade    = r_fade;
        n_eff     = r_eff;
        n_ovld    = r_ovld && !o_out.ready;
        n_oval    = r_oval;
        n_omode   = r_omode;
        n_t       = r_t;
        n_bn      = r_bn;
        n_dt      = r_dt;
        n_span    = r_span;
        n_sum     = r_sum;
        n_res     = r_res;
        mul_start = 1'b0;
        mul_a     = r_fade;
        mul_b     = seg.bri;
        div_start = 1'b0;
        div_dvd   = DIVD_W'(mul_prod + MUL_P_W'(EFF_HALF));
        div_dvs   = EFF_DIV;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_in.opcode)
                        OP_TICK: begin
                            n_t = i_in.second_of_day;
                            case (r_mode)
                                MODE_OFF: n_fade = '0;
                                MODE_FADE_IN: begin
                                    if (step >= 24'(FULL) || r_fade >= FULL - step[17:0]) begin
                                        n_fade = FULL;
                                        n_mode = MODE_ON;
                                    end else begin
                                        n_fade = r_fade + step[17:0];
                                    end
                                end
                                MODE_ON: n_fade = FULL;
                                default: begin
                                    if (step >= 24'(r_fade)) begin
                                        n_fade = '0;
                                        n_mode = MODE_OFF;
                                    end else begin
                                        n_fade = r_fade - step[17:0];
                                    end
                                end
                            endcase
                        end
                        OP_PIXEL: begin
                            mul_start = 1'b1;
                            mul_a     = r_eff;
                            mul_b     = {9'd0, i_in.channel_value};
                        end
                        OP_SWITCH: begin
                            n_mode = i_in.switch_on ? MODE_FADE_IN : MODE_FADE_OUT;
                            n_res  = eff_rnd[17:10];
                        end
                        default: n_res = eff_rnd[17:10];
                    endcase
                end
            end
            S_SCHED: begin
                mul_start = 1'b1;
                if (!seg.direct) begin
                    mul_a  = {1'b0, seg.bp};
                    mul_b  = seg.span - seg.dt;
                    n_bn   = seg.bn;
                    n_dt   = seg.dt;
                    n_span = seg.span;
                end
            end
            S_MUL1: begin
                if (mul_done) begin
                    n_sum     = mul_prod;
                    mul_start = 1'b1;
                    mul_a     = {1'b0, r_bn};
                    mul_b     = r_dt;
                end
            end
            S_MUL2: begin
                if (mul_done) begin
                    div_start = 1'b1;
                    div_dvd   = DIVD_W'(r_sum + mul_prod + MUL_P_W'(r_span >> 1));
                    div_dvs   = {1'b0, r_span};
                end
            end
            S_DIV_BRI: begin
                if (div_done) begin
                    mul_start = 1'b1;
                    mul_b     = div_quot[16:0];
                end
            end
            S_MUL_EFF: begin
                if (mul_done) begin
                    div_start = 1'b1;
                end
            end
            S_DIV_EFF: begin
                if (div_done) begin
                    n_eff = div_quot[17:0];
                    n_res = quot_rnd[17:10];
                end
            end
            S_MUL_PIX: begin
                if (mul_done) begin
                    div_start = 1'b1;
                    div_dvd   = DIVD_W'(mul_prod + MUL_P_W'(PIX_HALF));
                    div_dvs   = PIX_DIV;
                end
            end
            S_DIV_PIX: begin
                if (div_done) begin
                    n_res = div_quot[7:0];
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_ovld  = 1'b1;
                    n_oval  = r_res;
                    n_omode = r_mode;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_mode    <= MODE_OFF;
            r_fade    <= '0;
            r_eff     <= '0;
            r_ovld    <= 1'b0;
            r_enable  <= 1'b0;
            r_count   <= '0;
            r_pt_time <= '0;
            r_pt_bri  <= '0;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_fade  <= n_fade;
            r_eff   <= n_eff;
            r_ovld  <= n_ovld;
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.index == REG_ENABLE) begin
                    r_enable <= i_cfg.data[0];
                end else if (i_cfg.index == REG_COUNT) begin
                    r_count <= i_cfg.data[2:0];
                end else if (i_cfg.index inside {[REG_PT_A:REG_PT_D]}) begin
                    r_pt_time[2'(i_cfg.index - REG_PT_A)] <= i_cfg.data[16:0];
                    r_pt_bri[2'(i_cfg.index - REG_PT_A)]  <= b_sat;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_oval  <= n_oval;
        r_omode <= n_omode;
        r_t     <= n_t;
        r_bn    <= n_bn;
        r_dt    <= n_dt;
        r_span  <= n_span;
        r_sum   <= n_sum;
        r_res   <= n_res;
    end

    a_serial_units_exclusive: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) !(mul_busy && div_busy)
    ) else $error("multiplier and divider busy together");

    a_on_is_full: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCHED && r_mode == MODE_ON) |-> (r_fade == FULL)
    ) else $error("on mode after a tick without full level");

    a_off_is_zero: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCHED && r_mode == MODE_OFF) |-> (r_fade == '0)
    ) else $error("off mode after a tick with a nonzero level");

    a_accept_leaves_idle: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state != S_IDLE)
    ) else $error("accepted beat did not start work");

endmodule

`default_nettype wire
